>>> hw/rtl/positional_list_engine_macros.svh
// Assertion macros for the positional list engine checker.
// Depends on nothing; the using scope must provide clk and rst.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define PLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define PLE_ASSERT_NEXT_ALL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies.
package ple_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int OP_W         = 4;
  localparam int POS_W        = 8;
  localparam int VAL_W        = 32;
  localparam int ST_W         = 2;

  // Raw operation codes on the input stream
  localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 4'd2;
  localparam logic [OP_W-1:0] OP_READ_ALL  = 4'd3;
  localparam logic [OP_W-1:0] OP_READ_AT   = 4'd4;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 4'd5;
  localparam logic [OP_W-1:0] OP_REM_BACK  = 4'd6;
  localparam logic [OP_W-1:0] OP_REM_AT    = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_POS   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    KD_INSERT,
    KD_READ_ALL,
    KD_READ_AT,
    KD_REMOVE,
    KD_CLEAR,
    KD_NOP
  } kind_t;

  typedef enum logic [1:0] {
    WH_FRONT,
    WH_BACK,
    WH_AT
  } where_t;

  typedef struct packed {
    kind_t             kind;
    where_t            where;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ_ALL
  } back_state_t;

endpackage

>>> hw/rtl/ple_queue.sv
// Small first-in first-out queue of commands between front and back.
// No package dependencies; width and depth come from parameters.
module ple_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [FW-1:0] fill;
  logic          push;
  logic          pop;

  assign push_ready = (fill != FW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> hw/rtl/ple_front.sv
// Front stage: takes requests, decodes the op code into a command.
// Depends on ple_pkg.
module ple_front
  import ple_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  in_op,
  input  logic [POS_W-1:0] in_position,
  input  logic [VAL_W-1:0] in_value,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output cmd_t             cmd
);

  cmd_t decoded;

  always_comb begin
    decoded.position = in_position;
    decoded.value    = in_value;
    decoded.where    = WH_FRONT;
    unique case (in_op)
      OP_INS_FRONT: decoded.kind = KD_INSERT;
      OP_INS_BACK: begin
        decoded.kind  = KD_INSERT;
        decoded.where = WH_BACK;
      end
      OP_INS_AT: begin
        decoded.kind  = KD_INSERT;
        decoded.where = WH_AT;
      end
      OP_READ_ALL: decoded.kind = KD_READ_ALL;
      OP_READ_AT: begin
        decoded.kind  = KD_READ_AT;
        decoded.where = WH_AT;
      end
      OP_REM_FRONT: decoded.kind = KD_REMOVE;
      OP_REM_BACK: begin
        decoded.kind  = KD_REMOVE;
        decoded.where = WH_BACK;
      end
      OP_REM_AT: begin
        decoded.kind  = KD_REMOVE;
        decoded.where = WH_AT;
      end
      OP_CLEAR: decoded.kind = KD_CLEAR;
      default:  decoded.kind = KD_NOP;
    endcase
  end

  // Hold one decoded request; refill as soon as it moves on
  assign in_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= decoded;
    end
  end

endmodule

>>> hw/rtl/ple_back.sv
// Back stage: list cells, element count, read-all sequencer, result register.
// Depends on ple_pkg.
module ple_back
  import ple_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output status_t          out_status,
  output logic [VAL_W-1:0] out_value,
  output logic [CNT_W-1:0] out_count,
  output logic             out_last
);

  localparam int IDX_W = $clog2(CAPACITY);

  logic [VAL_W-1:0] cells [CAPACITY];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] ridx;
  logic [IDX_W-1:0] ridx_next;
  back_state_t      state;
  back_state_t      state_next;

  logic             slot_free;
  logic             is_full;
  logic             is_empty;
  logic             pos_ok;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [VAL_W-1:0] rd_value;
  logic             do_ins;
  logic             do_rem;
  logic             load;
  status_t          r_status;
  logic [VAL_W-1:0] r_value;
  logic             r_last;

  assign slot_free = !out_valid || out_ready;
  assign is_full   = (count == CNT_W'(CAPACITY));
  assign is_empty  = (count == '0);
  assign pos_ok    = (cmd.position != '0) && (cmd.position <= POS_W'(count));
  assign pos_idx   = IDX_W'(cmd.position - 1'b1);
  assign rd_idx    = (state == BK_READ_ALL) ? ridx : sel_idx;
  assign rd_value  = cells[rd_idx];

  always_comb begin
    unique case (cmd.where)
      WH_FRONT: sel_idx = '0;
      WH_BACK:  sel_idx = (cmd.kind == KD_INSERT) ? IDX_W'(count) : IDX_W'(count - 1'b1);
      WH_AT:    sel_idx = pos_idx;
      default:  sel_idx = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    ridx_next  = ridx;
    count_next = count;
    cmd_ready  = 1'b0;
    load       = 1'b0;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    r_status   = ST_OK;
    r_value    = '0;
    r_last     = 1'b1;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_ready = 1'b1;
          load      = 1'b1;
          unique case (cmd.kind)
            KD_INSERT: begin
              if (cmd.where == WH_AT && !pos_ok) begin
                r_status = ST_POS;
              end else if (is_full) begin
                r_status = ST_FULL;
              end else begin
                do_ins     = 1'b1;
                count_next = count + 1'b1;
              end
            end
            KD_READ_ALL: begin
              if (is_empty) begin
                r_status = ST_EMPTY;
              end else begin
                // elements come out of the sequencer instead
                load       = 1'b0;
                ridx_next  = '0;
                state_next = BK_READ_ALL;
              end
            end
            KD_READ_AT: begin
              if (is_empty) begin
                r_status = ST_EMPTY;
              end else if (!pos_ok) begin
                r_status = ST_POS;
              end else begin
                r_value = rd_value;
              end
            end
            KD_REMOVE: begin
              if (is_empty) begin
                r_status = ST_EMPTY;
              end else if (cmd.where == WH_AT && !pos_ok) begin
                r_status = ST_POS;
              end else begin
                r_value    = rd_value;
                do_rem     = 1'b1;
                count_next = count - 1'b1;
              end
            end
            KD_CLEAR: count_next = '0;
            default: ;
          endcase
        end
      end
      BK_READ_ALL: begin
        if (slot_free) begin
          load    = 1'b1;
          r_value = rd_value;
          r_last  = ((CNT_W'(ridx) + 1'b1) == count);
          if (r_last) begin
            state_next = BK_IDLE;
          end else begin
            ridx_next = ridx + 1'b1;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Shift cells in parallel: open a gap on insert, close it on remove
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (IDX_W'(i) == sel_idx) begin
          cells[i] <= cmd.value;
        end else if (i > 0 && IDX_W'(i) > sel_idx) begin
          cells[i] <= cells[(i > 0) ? i - 1 : 0];
        end
      end else if (do_rem) begin
        if (i < CAPACITY - 1 && IDX_W'(i) >= sel_idx) begin
          cells[i] <= cells[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      ridx      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ridx  <= ridx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= r_status;
      out_value  <= r_value;
      out_count  <= count_next;
      out_last   <= r_last;
    end
  end

endmodule

>>> hw/rtl/positional_list_engine.sv
// Positional list engine, top level. Ties front, command queue and back together.
// Depends on ple_pkg, ple_front, ple_queue, ple_back.
//
// An ordered list of up to CAPACITY signed 32-bit values, kept packed in
// register cells in list order. Each request carries an op code on tuser
// (insert at front, back or a 1-based position; read all; read at a position;
// remove front, back or at a position; clear) and a position and a value on
// tdata. Every request
// answers with one result (status, value read or removed, element count after
// the operation, tlast set), except a read-all of a non-empty list, which
// answers with one result per element, front first, tlast on the final one.
// Status codes: ok, list empty, list full, position out of range; the value is
// zero on every error. Insert at a position accepts positions 1 to count only.
// Unknown op codes leave the list alone and answer ok with the current count.
// Rate: the front takes one request per cycle into a two-entry queue; the back
// executes an ordinary request while shifting all cells in parallel, so requests
// sustain one per cycle while no read-all or output back-pressure holds them. A
// result goes valid once its request has passed the front register, the queue
// and the result register. A read-all holds the back, which takes no new request
// until the sequencer has fed every element through the single result register.
// Output back-pressure stalls the back first, then the queue, then the front.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int CNT_W   = $clog2(CAPACITY + 1),
  localparam int IN_W    = ((POS_W + VAL_W + 7) / 8) * 8,
  localparam int OUT_W   = ((ST_W + VAL_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // request stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // position[7:0], value[39:8]
  input  logic [OP_W-1:0]  s_axis_tuser,   // op[3:0]
  // result stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // status[1:0], value_res[33:2], count[38:34]
  output logic             m_axis_tlast    // final result of the request
);

  localparam int CMD_W = $bits(cmd_t);

  logic             front_valid;
  logic             front_ready;
  cmd_t             front_cmd;
  logic             back_valid;
  logic             back_ready;
  logic [CMD_W-1:0] back_bits;
  cmd_t             back_cmd;
  status_t          res_status;
  logic [VAL_W-1:0] res_value;
  logic [CNT_W-1:0] res_count;

  // Decode and hold the incoming request
  ple_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_op       (s_axis_tuser),
    .in_position (s_axis_tdata[POS_W-1:0]),
    .in_value    (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
    .cmd_valid   (front_valid),
    .cmd_ready   (front_ready),
    .cmd         (front_cmd)
  );

  // Decouple front from back
  ple_queue #(
    .W     (CMD_W),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_bits)
  );

  assign back_cmd = cmd_t'(back_bits);

  // Execute against the list cells and register the result
  ple_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (back_valid),
    .cmd_ready  (back_ready),
    .cmd        (back_cmd),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (res_status),
    .out_value  (res_value),
    .out_count  (res_count),
    .out_last   (m_axis_tlast)
  );

  // Pack result fields, lowest first, zero-fill to whole bytes
  assign m_axis_tdata = OUT_W'({res_count, res_value, res_status});

endmodule

>>> hw/rtl/ple_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine_macros.svh.
`include "positional_list_engine_macros.svh"

module ple_checker
  import ple_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int CNT_W   = $clog2(CAPACITY + 1),
  localparam int OUT_W   = ((ST_W + VAL_W + CNT_W + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  logic [ST_W-1:0]  st;
  logic [VAL_W-1:0] val;
  logic [CNT_W-1:0] cnt;
  logic             mid_seen;
  logic [CNT_W-1:0] mid_count;
  logic             in_seen;

  assign st  = m_axis_tdata[ST_W-1:0];
  assign val = m_axis_tdata[ST_W+VAL_W-1:ST_W];
  assign cnt = m_axis_tdata[ST_W+VAL_W+CNT_W-1:ST_W+VAL_W];

  // Track a read-all in progress and note input activity
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_seen <= 1'b0;
      in_seen  <= 1'b0;
    end else begin
      in_seen <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        mid_seen  <= !m_axis_tlast;
        mid_count <= cnt;
      end
    end
  end

  `PLE_ASSERT_NEXT_ALL(a_reset_clears_out, rst, !m_axis_tvalid, "result valid after reset")
  `PLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
  `PLE_ASSERT_NOW(a_error_single, m_axis_tvalid && (st != ST_OK), m_axis_tlast && (val == '0), "error result not single or has value")
  `PLE_ASSERT_NOW(a_readall_steady, m_axis_tvalid && mid_seen, (st == ST_OK) && (cnt == mid_count), "read-all run changed status or count")
  `PLE_ASSERT_NOW(a_count_bound, m_axis_tvalid || in_seen, !m_axis_tvalid || (cnt <= CNT_W'(CAPACITY)), "count beyond capacity")

endmodule

bind positional_list_engine ple_checker #(
  .CAPACITY (CAPACITY)
) u_ple_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the positional list engine: requests go in, results are predicted
// from a shadow copy of the list and compared field by field. Depends on ple_pkg and the RTL.
module testbench;
  import ple_pkg::*;

  localparam int CNT_W       = $clog2(DEF_CAPACITY + 1);
  localparam int REQ_W       = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int RES_W       = ((ST_W + VAL_W + CNT_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic             last;
  } list_result_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [REQ_W-1:0] s_axis_tdata = '0;  // position, value
  logic [OP_W-1:0]  s_axis_tuser = '0;  // op
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [RES_W-1:0] m_axis_tdata;       // status, value_res, count
  logic             m_axis_tlast;

  // Shadow list and the results it says are still owed
  logic [VAL_W-1:0] shadow_cells [DEF_CAPACITY];
  int               shadow_count = 0;
  list_result_t     pending_results [$];
  int               mismatch_count = 0;
  bit               idling_on = 1'b1;
  int               quiet_cycles = 0;

  positional_list_engine dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow list
  // ---------------------------------------------------------------------------
  function automatic void insert_cell(input int idx, input logic [VAL_W-1:0] v);
    for (int i = shadow_count; i > idx; i--) shadow_cells[i] = shadow_cells[i-1];
    shadow_cells[idx] = v;
    shadow_count++;
  endfunction

  function automatic logic [VAL_W-1:0] remove_cell(input int idx);
    logic [VAL_W-1:0] v;
    v = shadow_cells[idx];
    for (int i = idx; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i+1];
    shadow_count--;
    return v;
  endfunction

  function automatic void push_result(input status_t st, input logic [VAL_W-1:0] v,
                                      input logic last);
    list_result_t r;
    r.status = st;
    r.value  = v;
    r.count  = shadow_count[CNT_W-1:0];
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted request to the shadow list and queue what it answers
  function automatic void apply_list_request(input logic [OP_W-1:0] op,
                                             input logic [POS_W-1:0] pos,
                                             input logic [VAL_W-1:0] val);
    bit               pos_ok;
    bit               full;
    status_t          st;
    logic [VAL_W-1:0] rv;
    pos_ok = (pos >= 1) && (pos <= shadow_count);
    full   = shadow_count >= DEF_CAPACITY;
    st     = ST_OK;
    rv     = '0;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) st = ST_FULL;
        else insert_cell(op == OP_INS_FRONT ? 0 : shadow_count, val);
      end
      OP_INS_AT: begin
        // position is checked before capacity
        if (!pos_ok) st = ST_POS;
        else if (full) st = ST_FULL;
        else insert_cell(pos - 1, val);
      end
      OP_READ_ALL: begin
        if (shadow_count == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < shadow_count; i++)
            push_result(ST_OK, shadow_cells[i], i + 1 == shadow_count);
          return;
        end
      end
      OP_READ_AT: begin
        if (shadow_count == 0) st = ST_EMPTY;
        else if (!pos_ok) st = ST_POS;
        else rv = shadow_cells[pos - 1];
      end
      OP_REM_FRONT, OP_REM_BACK: begin
        if (shadow_count == 0) st = ST_EMPTY;
        else rv = remove_cell(op == OP_REM_FRONT ? 0 : shadow_count - 1);
      end
      OP_REM_AT: begin
        if (shadow_count == 0) st = ST_EMPTY;
        else if (!pos_ok) st = ST_POS;
        else rv = remove_cell(pos - 1);
      end
      OP_CLEAR: shadow_count = 0;
      default: ;  // unknown codes leave the list alone
    endcase
    push_result(st, rv, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: change at the falling edge, take the handshake at the rising one
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= REQ_W'({val, pos});
    do @(posedge clk); while (!s_axis_tready);
    apply_list_request(op, pos, val);
  endtask

  // Result side back-pressure in bursts
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if (idling_on && $urandom_range(0, 7) == 0) hold = $urandom_range(1, 6);
      end
    end
  end

  // Compare each result against the oldest owed one
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing owed: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[ST_W-1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[ST_W-1:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[ST_W+VAL_W-1:ST_W] !== want.value) begin
          $error("value_res: expected %0d, got %0d", $signed(want.value),
                 $signed(m_axis_tdata[ST_W+VAL_W-1:ST_W]));
          mismatch_count++;
        end
        if (m_axis_tdata[ST_W+VAL_W+CNT_W-1:ST_W+VAL_W] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count,
                 m_axis_tdata[ST_W+VAL_W+CNT_W-1:ST_W+VAL_W]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------
  function automatic logic [POS_W-1:0] pick_position();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7 && shadow_count > 0) return POS_W'($urandom_range(1, shadow_count));
    if (roll == 7) return POS_W'(shadow_count + 1);
    if (roll == 8) return '0;
    return POS_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return '0;
    endcase
  endfunction

  // Drift the list toward full, then toward empty, so both ends get hit often
  task automatic run_random_requests(input int total);
    int               roll;
    int               ins_cut;
    bit               growing;
    logic [OP_W-1:0]  op;
    growing = 1'b1;
    repeat (total) begin
      if (shadow_count >= DEF_CAPACITY) growing = 1'b0;
      else if (shadow_count == 0) growing = 1'b1;
      ins_cut = growing ? 55 : 20;
      roll = $urandom_range(0, 99);
      if (roll < ins_cut) begin
        case ($urandom_range(0, 2))
          0: op = OP_INS_FRONT;
          1: op = OP_INS_BACK;
          default: op = OP_INS_AT;
        endcase
      end else if (roll < ins_cut + 15) begin
        op = OP_READ_AT;
      end else if (roll < 88) begin
        case ($urandom_range(0, 2))
          0: op = OP_REM_FRONT;
          1: op = OP_REM_BACK;
          default: op = OP_REM_AT;
        endcase
      end else if (roll < 94) begin
        op = OP_READ_ALL;
      end else if (roll < 96) begin
        op = OP_CLEAR;
      end else begin
        op = OP_W'($urandom_range(int'(OP_CLEAR) + 1, (1 << OP_W) - 1));
      end
      send_request(op, pick_position(), pick_value());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reads, removes, insert at a position, clear and unknown codes against an empty list
  task automatic test_empty_list();
    send_request(OP_READ_ALL, 8'd0, '0);
    send_request(OP_READ_AT, 8'd1, '0);
    send_request(OP_REM_FRONT, 8'd0, '0);
    send_request(OP_REM_BACK, 8'd0, '0);
    send_request(OP_REM_AT, 8'd1, '0);
    send_request(OP_INS_AT, 8'd1, 32'h1234_5678);  // position check wins on empty
    send_request(OP_CLEAR, 8'd0, '0);
    send_request({OP_W{1'b1}}, 8'hFF, 32'hFFFF_FFFF);
    send_request(OP_W'(int'(OP_CLEAR) + 1), 8'd3, 32'd7);
  endtask

  // Value extremes and positions at and beyond both ends
  task automatic test_positions();
    send_request(OP_INS_BACK, 8'd0, 32'h7FFF_FFFF);
    send_request(OP_INS_FRONT, 8'd0, 32'h8000_0000);
    send_request(OP_INS_AT, 8'd1, 32'h0000_0000);
    send_request(OP_INS_AT, 8'd3, 32'hFFFF_FFFF);   // at count
    send_request(OP_INS_AT, 8'd5, 32'd1);           // count + 1 is refused
    send_request(OP_INS_AT, 8'd0, 32'd1);
    send_request(OP_READ_AT, 8'd0, '0);
    send_request(OP_READ_AT, 8'd255, '0);
    send_request(OP_READ_AT, 8'd4, '0);
    send_request(OP_READ_ALL, 8'd0, '0);
    send_request(OP_REM_AT, 8'd2, '0);
    send_request(OP_REM_FRONT, 8'd0, '0);
    send_request(OP_REM_BACK, 8'd0, '0);
    send_request(OP_REM_AT, 8'd2, '0);
    send_request(OP_REM_AT, 8'd1, '0);
  endtask

  // Fill to capacity, hit the full cases, read the whole list, remove and read near the back, then clear and read again
  task automatic test_capacity();
    for (int i = 0; i < DEF_CAPACITY; i++)
      send_request(i % 2 ? OP_INS_FRONT : OP_INS_BACK, 8'd0, $urandom);
    send_request(OP_INS_FRONT, 8'd0, 32'd1);
    send_request(OP_INS_BACK, 8'd0, 32'd2);
    send_request(OP_INS_AT, 8'd8, 32'd3);
    send_request(OP_INS_AT, 8'(DEF_CAPACITY + 1), 32'd4);
    send_request(OP_READ_ALL, 8'd0, '0);
    send_request(OP_REM_AT, 8'(DEF_CAPACITY), '0);
    send_request(OP_READ_AT, 8'(DEF_CAPACITY - 1), '0);
    send_request(OP_CLEAR, 8'd0, '0);
    send_request(OP_READ_ALL, 8'd0, '0);
  endtask

  // Random requests with idling on both sides, one quiet stretch in the middle
  task automatic test_random_mixed();
    for (int chunk = 0; chunk < 4; chunk++) begin
      idling_on = (chunk != 2);
      run_random_requests(30);
    end
  endtask

  // Closing random stretch at full rate
  task automatic test_random_steady();
    idling_on = 1'b0;
    run_random_requests(40);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_positions();
    test_capacity();
    test_random_mixed();
    test_random_steady();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
